/* rtl/sohbcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SOH/length frame codec package
// Item types, codes and job descriptors shared by the framer front end,
// the job queue and the result sequencer.
// ----------------------------------------------------------------------------
package sohbcc_pkg;

    localparam int          MAX_PAYLOAD = 256;
    localparam logic [7:0]  SOH_BYTE    = 8'h01;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TX_START = 2'd0,
        CMD_TX_BYTE  = 2'd1,
        CMD_RX_BYTE  = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_LINE    = 2'd0,
        KIND_RX_DATA = 2'd1,
        KIND_RX_END  = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_BAD_START = 2'd2,
        ST_BAD_CHECK = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ADDR  = 3'd1,
        PH_LENH  = 3'd2,
        PH_LENL  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_rx_phase;

    typedef enum logic [1:0] {
        JOB_HDR     = 2'd0,
        JOB_TX_BYTE = 2'd1,
        JOB_SINGLE  = 2'd2
    } t_job_op;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [15:0] frame_len;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [8:0] rx_length;
        logic       hold_off;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_job_op    op;
        t_kind      kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] chk;
        t_status    status;
        logic [8:0] rx_length;
        logic       hold;
        logic       fin;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_job_push;

endpackage

`default_nettype wire

/* rtl/sohbcc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Short FIFO of job descriptors between the front end and the sequencer.
// ----------------------------------------------------------------------------
module sohbcc_queue
    import sohbcc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job_push i_wr,
    output logic           o_full,
    output logic           o_valid,
    output t_job           o_job,
    input  wire logic      i_pop
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QCNT_W-1:0]   n_cnt;
    logic                push;
    logic                pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_wr.push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_wr.job;
        end
    end

endmodule

`default_nettype wire

/* rtl/sohbcc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Codec front end
// Accepts items, tracks transmit and receive framing state and emits one
// job descriptor per item that causes results.
// ----------------------------------------------------------------------------
module sohbcc_front
    import sohbcc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_full,
    output logic          o_stall,
    output t_job_push     o_wr
);

    logic [8:0]  r_tx_rem,  n_tx_rem;
    logic [7:0]  r_tx_chk,  n_tx_chk;
    t_rx_phase   r_phase,   n_phase;
    logic [15:0] r_rx_exp,  n_rx_exp;
    logic [8:0]  r_rx_cnt,  n_rx_cnt;
    logic [7:0]  r_rx_chk,  n_rx_chk;
    logic        r_err,     n_err;

    logic        acc;
    t_cmd        cmd;
    logic [7:0]  b;
    logic [15:0] len;
    logic        len_long;
    logic [7:0]  tx_hdr_chk;
    logic [15:0] rx_len_full;
    logic        rx_len_long;
    logic [8:0]  rx_cnt_inc;
    logic        rx_bad;

    assign o_stall     = i_full;
    assign acc         = i_valid && !i_full;
    assign cmd         = t_cmd'(i_item.cmd);
    assign b           = i_item.data_byte;
    assign len         = i_item.frame_len;
    assign len_long    = (len > 16'(MAX_PAYLOAD));
    assign tx_hdr_chk  = SOH_BYTE ^ len[15:8] ^ len[7:0];
    assign rx_len_full = {r_rx_exp[15:8], b};
    assign rx_len_long = (rx_len_full > 16'(MAX_PAYLOAD));
    assign rx_cnt_inc  = r_rx_cnt + 9'd1;
    assign rx_bad      = ((r_rx_chk ^ b) != 8'h00);

    always_comb begin
        n_tx_rem = r_tx_rem;
        n_tx_chk = r_tx_chk;
        n_phase  = r_phase;
        n_rx_exp = r_rx_exp;
        n_rx_cnt = r_rx_cnt;
        n_rx_chk = r_rx_chk;
        n_err    = r_err;
        if (acc) begin
            unique case (cmd)
                CMD_TX_START: begin
                    if (len_long) begin
                        n_tx_rem = '0;
                    end else begin
                        n_tx_rem = len[8:0];
                        n_tx_chk = tx_hdr_chk;
                        n_err    = 1'b0;
                    end
                end
                CMD_TX_BYTE: begin
                    if (r_tx_rem != '0) begin
                        n_tx_chk = r_tx_chk ^ b;
                        n_tx_rem = r_tx_rem - 9'd1;
                    end
                end
                CMD_RX_BYTE: begin
                    unique case (r_phase)
                        PH_ADDR: begin
                            n_rx_chk = r_rx_chk ^ b;
                            n_phase  = PH_LENH;
                        end
                        PH_LENH: begin
                            n_rx_chk = r_rx_chk ^ b;
                            n_rx_exp = {b, 8'h00};
                            n_phase  = PH_LENL;
                        end
                        PH_LENL: begin
                            n_rx_chk = r_rx_chk ^ b;
                            n_rx_exp = rx_len_full;
                            n_rx_cnt = '0;
                            if (rx_len_long) begin
                                n_err   = 1'b1;
                                n_phase = PH_START;
                            end else if (rx_len_full == 16'h0000) begin
                                n_phase = PH_CHECK;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            n_rx_chk = r_rx_chk ^ b;
                            n_rx_cnt = rx_cnt_inc;
                            if ({7'd0, rx_cnt_inc} >= r_rx_exp) begin
                                n_phase = PH_CHECK;
                            end
                        end
                        PH_CHECK: begin
                            n_rx_chk = r_rx_chk ^ b;
                            if (rx_bad) begin
                                n_err = 1'b1;
                            end
                            n_phase = PH_START;
                        end
                        default: begin
                            if (b != SOH_BYTE) begin
                                n_err   = 1'b1;
                                n_phase = PH_START;
                            end else begin
                                n_rx_chk = b;
                                n_phase  = PH_ADDR;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_wr           = '0;
        o_wr.job.op    = JOB_SINGLE;
        o_wr.job.kind  = KIND_LINE;
        o_wr.job.status = ST_OK;
        unique case (cmd)
            CMD_TX_START: begin
                o_wr.push = acc;
                if (len_long) begin
                    o_wr.job.kind   = KIND_ERROR;
                    o_wr.job.status = ST_TOO_LONG;
                end else begin
                    o_wr.job.op     = JOB_HDR;
                    o_wr.job.byte_a = len[15:8];
                    o_wr.job.byte_b = len[7:0];
                    o_wr.job.chk    = tx_hdr_chk;
                    o_wr.job.hold   = r_err;
                    o_wr.job.fin    = (len == 16'h0000);
                end
            end
            CMD_TX_BYTE: begin
                o_wr.push       = acc && (r_tx_rem != '0);
                o_wr.job.op     = JOB_TX_BYTE;
                o_wr.job.byte_a = b;
                o_wr.job.chk    = r_tx_chk ^ b;
                o_wr.job.fin    = (r_tx_rem == 9'd1);
            end
            CMD_RX_BYTE: begin
                o_wr.job.byte_a = b;
                unique case (r_phase)
                    PH_ADDR, PH_LENH: ;
                    PH_LENL: begin
                        o_wr.push       = acc && rx_len_long;
                        o_wr.job.kind   = KIND_ERROR;
                        o_wr.job.status = ST_TOO_LONG;
                    end
                    PH_DATA: begin
                        o_wr.push     = acc;
                        o_wr.job.kind = KIND_RX_DATA;
                    end
                    PH_CHECK: begin
                        o_wr.push           = acc;
                        o_wr.job.kind       = KIND_RX_END;
                        o_wr.job.byte_a     = 8'h00;
                        o_wr.job.status     = rx_bad ? ST_BAD_CHECK : ST_OK;
                        o_wr.job.rx_length  = r_rx_cnt;
                    end
                    default: begin
                        o_wr.push       = acc && (b != SOH_BYTE);
                        o_wr.job.kind   = KIND_ERROR;
                        o_wr.job.status = ST_BAD_START;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_rem <= '0;
            r_tx_chk <= '0;
            r_phase  <= PH_START;
            r_rx_exp <= '0;
            r_rx_cnt <= '0;
            r_rx_chk <= '0;
            r_err    <= 1'b0;
        end else begin
            r_tx_rem <= n_tx_rem;
            r_tx_chk <= n_tx_chk;
            r_phase  <= n_phase;
            r_rx_exp <= n_rx_exp;
            r_rx_cnt <= n_rx_cnt;
            r_rx_chk <= n_rx_chk;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

/* rtl/sohbcc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Result sequencer
// Expands each queued job into its result items, one per cycle unless
// stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module sohbcc_back
    import sohbcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_job_valid,
    input  wire t_job  i_job,
    output logic       o_pop,
    output logic       o_valid,
    output t_out_item  o_item,
    input  wire logic  i_stall
);

    logic [2:0] r_step;
    logic       r_valid;
    t_out_item  r_item;
    t_out_item  res;
    logic       done;
    logic       load;

    assign load    = i_job_valid && (!r_valid || !i_stall);
    assign o_pop   = load && done;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        res          = '0;
        res.kind     = KIND_LINE;
        done         = 1'b1;
        unique case (i_job.op)
            JOB_HDR: begin
                done = i_job.fin ? (r_step == 3'd4) : (r_step == 3'd3);
                unique case (r_step)
                    3'd0: begin
                        res.out_byte = SOH_BYTE;
                        res.hold_off = i_job.hold;
                    end
                    3'd1: res.out_byte = 8'h00;
                    3'd2: res.out_byte = i_job.byte_a;
                    3'd3: begin
                        res.out_byte = i_job.byte_b;
                        res.last     = i_job.fin;
                    end
                    default: begin
                        res.out_byte = i_job.chk;
                        res.last     = 1'b1;
                    end
                endcase
            end
            JOB_TX_BYTE: begin
                done = i_job.fin ? (r_step == 3'd1) : (r_step == 3'd0);
                if (r_step == 3'd0) begin
                    res.out_byte = i_job.byte_a;
                    res.last     = i_job.fin;
                end else begin
                    res.out_byte = i_job.chk;
                    res.last     = 1'b1;
                end
            end
            JOB_SINGLE: begin
                res.kind      = i_job.kind;
                res.out_byte  = i_job.byte_a;
                res.status    = i_job.status;
                res.rx_length = i_job.rx_length;
                res.last      = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            priority if (load) begin
                r_valid <= 1'b1;
                r_step  <= done ? 3'd0 : r_step + 3'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= res;
        end
    end

endmodule

`default_nettype wire

/* rtl/soh_length_bcc_frame_codec_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SOH/length frame codec core
// Framer and deframer for a serial reader link with an XOR block check.
// ----------------------------------------------------------------------------
// The input channel takes one item per cycle as long as the four-entry job
// queue has room; each item is classified and updates the framing state in
// the cycle it is accepted. The result sequencer drains the queue and gives
// one result item per cycle from its output register unless stalled: a
// transmit start gives 4 or 5 items (1 if too long), a payload byte 1, 2 or
// none, every other item 1 or none. Results pass the job queue and then the
// output register, which alone sets throughput: one result per cycle.
// ----------------------------------------------------------------------------
module soh_length_bcc_frame_codec_core
    import sohbcc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_item,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_item,
    input  wire logic      i_out_stall
);

    t_job_push wr;
    logic      q_full;
    logic      q_valid;
    t_job      q_job;
    logic      q_pop;

    sohbcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_wr    (wr)
    );

    sohbcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    sohbcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item),
        .i_stall     (i_out_stall)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.push |-> !q_full)
        else $error("job pushed into full queue");

    a_hold_off_on_soh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.hold_off) |->
        (o_out_item.kind == KIND_LINE && o_out_item.out_byte == SOH_BYTE))
        else $error("hold_off outside first header byte");

    a_rx_length_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rx_length != '0) |-> (o_out_item.kind == KIND_RX_END))
        else $error("rx_length outside frame end");

    a_pop_only_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out_valid)
        else $error("job retired without result");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SOH/length frame codec core testbench
// Feeds transmit starts, payload bytes and received line bytes through the
// valid/stall input channel and checks every output item against a
// cycle-free model of the framer, deframer and sticky error flag. Covers
// directed corner frames, then random well-formed and broken frames, with
// sender idling and receiver stalls varied per phase.
// ----------------------------------------------------------------------------
module tb;
    import sohbcc_pkg::*;

    localparam int HANG_CYCLES = 4000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 60;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    soh_length_bcc_frame_codec_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(i_out_stall)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_in_item  item_q[$];
    t_in_item  tx_seq[$];
    t_in_item  rx_seq[$];
    t_out_item codec_out_q[$];
    t_out_item want_item;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hang_count  = 0;
    int n_fail      = 0;
    int n_in_items  = 0;
    int n_results   = 0;
    int n_tx_frames = 0;
    int n_rx_frames = 0;

    logic [8:0]  tx_left    = '0;
    logic [7:0]  tx_bcc     = '0;
    t_rx_phase   rx_ph      = PH_START;
    logic [15:0] rx_len     = '0;
    logic [8:0]  rx_cnt     = '0;
    logic [7:0]  rx_bcc     = '0;
    logic        err_sticky = 1'b0;

    function automatic t_in_item mk(t_cmd c, logic [7:0] b, logic [15:0] len);
        t_in_item it;
        it.cmd       = c;
        it.data_byte = b;
        it.frame_len = len;
        return it;
    endfunction

    function automatic void push_result(t_kind k, logic [7:0] b, t_status s,
                                        logic [8:0] n, logic hold, logic fin);
        t_out_item r;
        r.kind      = k;
        r.out_byte  = b;
        r.status    = s;
        r.rx_length = n;
        r.hold_off  = hold;
        r.last      = fin;
        codec_out_q.push_back(r);
    endfunction

    function automatic void codec_predict(t_in_item it);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] b;
        logic       bad;
        hi = it.frame_len[15:8];
        lo = it.frame_len[7:0];
        b  = it.data_byte;
        case (it.cmd)
            CMD_TX_START: begin
                if (it.frame_len > MAX_PAYLOAD) begin
                    tx_left = '0;
                    push_result(KIND_ERROR, 8'h00, ST_TOO_LONG, 9'd0, 1'b0, 1'b1);
                end else begin
                    tx_bcc  = SOH_BYTE ^ 8'h00 ^ hi ^ lo;
                    tx_left = it.frame_len[8:0];
                    push_result(KIND_LINE, SOH_BYTE, ST_OK, 9'd0, err_sticky, 1'b0);
                    err_sticky = 1'b0;
                    push_result(KIND_LINE, 8'h00, ST_OK, 9'd0, 1'b0, 1'b0);
                    push_result(KIND_LINE, hi, ST_OK, 9'd0, 1'b0, 1'b0);
                    push_result(KIND_LINE, lo, ST_OK, 9'd0, 1'b0, it.frame_len == 0);
                    if (it.frame_len == 0)
                        push_result(KIND_LINE, tx_bcc, ST_OK, 9'd0, 1'b0, 1'b1);
                end
            end
            CMD_TX_BYTE: begin
                if (tx_left != 0) begin
                    tx_bcc  = tx_bcc ^ b;
                    tx_left = tx_left - 9'd1;
                    push_result(KIND_LINE, b, ST_OK, 9'd0, 1'b0, tx_left == 0);
                    if (tx_left == 0)
                        push_result(KIND_LINE, tx_bcc, ST_OK, 9'd0, 1'b0, 1'b1);
                end
            end
            CMD_RX_BYTE: begin
                case (rx_ph)
                    PH_ADDR: begin
                        rx_bcc = rx_bcc ^ b;
                        rx_ph  = PH_LENH;
                    end
                    PH_LENH: begin
                        rx_bcc = rx_bcc ^ b;
                        rx_len = {b, 8'h00};
                        rx_ph  = PH_LENL;
                    end
                    PH_LENL: begin
                        rx_bcc      = rx_bcc ^ b;
                        rx_len[7:0] = b;
                        rx_cnt      = '0;
                        if (rx_len > MAX_PAYLOAD) begin
                            err_sticky = 1'b1;
                            rx_ph      = PH_START;
                            push_result(KIND_ERROR, b, ST_TOO_LONG, 9'd0, 1'b0, 1'b1);
                        end else begin
                            rx_ph = (rx_len == 0) ? PH_CHECK : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        rx_bcc = rx_bcc ^ b;
                        rx_cnt = rx_cnt + 9'd1;
                        if (rx_cnt >= rx_len)
                            rx_ph = PH_CHECK;
                        push_result(KIND_RX_DATA, b, ST_OK, 9'd0, 1'b0, 1'b1);
                    end
                    PH_CHECK: begin
                        bad    = (rx_bcc ^ b) != 8'h00;
                        rx_bcc = rx_bcc ^ b;
                        if (bad)
                            err_sticky = 1'b1;
                        rx_ph = PH_START;
                        if (bad)
                            push_result(KIND_RX_END, 8'h00, ST_BAD_CHECK, rx_cnt, 1'b0, 1'b1);
                        else
                            push_result(KIND_RX_END, 8'h00, ST_OK, rx_cnt, 1'b0, 1'b1);
                    end
                    default: begin
                        if (b != SOH_BYTE) begin
                            err_sticky = 1'b1;
                            rx_ph      = PH_START;
                            push_result(KIND_ERROR, b, ST_BAD_START, 9'd0, 1'b0, 1'b1);
                        end else begin
                            rx_bcc = b;
                            rx_ph  = PH_ADDR;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int add_tx(logic [15:0] len, int n_bytes);
        tx_seq.push_back(mk(CMD_TX_START, 8'($urandom), len));
        for (int i = 0; i < n_bytes; i++)
            tx_seq.push_back(mk(CMD_TX_BYTE, 8'($urandom), 16'($urandom)));
        n_tx_frames++;
        return n_bytes + 1;
    endfunction

    function automatic int add_rx(logic [15:0] len, bit bad_chk, bit cut);
        logic [7:0] addr;
        logic [7:0] bcc;
        logic [7:0] b;
        int         n_data;
        addr = 8'($urandom);
        bcc  = SOH_BYTE ^ addr ^ len[15:8] ^ len[7:0];
        rx_seq.push_back(mk(CMD_RX_BYTE, SOH_BYTE, 16'($urandom)));
        rx_seq.push_back(mk(CMD_RX_BYTE, addr, 16'($urandom)));
        rx_seq.push_back(mk(CMD_RX_BYTE, len[15:8], 16'($urandom)));
        rx_seq.push_back(mk(CMD_RX_BYTE, len[7:0], 16'($urandom)));
        n_rx_frames++;
        if (len > MAX_PAYLOAD)
            return 4;
        n_data = (cut && len != 0) ? int'($urandom_range(len - 1)) : int'(len);
        for (int i = 0; i < n_data; i++) begin
            b   = 8'($urandom);
            bcc = bcc ^ b;
            rx_seq.push_back(mk(CMD_RX_BYTE, b, 16'($urandom)));
        end
        if (cut)
            return n_data + 4;
        if (bad_chk)
            bcc = bcc ^ 8'($urandom_range(1, 255));
        rx_seq.push_back(mk(CMD_RX_BYTE, bcc, 16'($urandom)));
        return n_data + 5;
    endfunction

    function automatic void merge_seqs(bit mix);
        while (tx_seq.size() != 0 || rx_seq.size() != 0) begin
            if (rx_seq.size() == 0 || (tx_seq.size() != 0 && (!mix || $urandom_range(1) == 1)))
                item_q.push_back(tx_seq.pop_front());
            else
                item_q.push_back(rx_seq.pop_front());
        end
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return 256 - $urandom_range(1);
        if (r < 10)
            return 0;
        if (r < 20)
            return $urandom_range(9, 40);
        if (r < 28)
            return $urandom_range(257, 65535);
        return $urandom_range(1, 8);
    endfunction

    function automatic void gen_random(int n_target);
        int n_made;
        int r;
        int len;
        int sent;
        n_made = 0;
        while (n_made < n_target) begin
            r = $urandom_range(99);
            if (r < 40) begin
                len  = pick_len();
                sent = (len > MAX_PAYLOAD) ? $urandom_range(2) : len;
                if (len <= MAX_PAYLOAD && $urandom_range(9) == 0)
                    sent = $urandom_range(len + 1);
                n_made += add_tx(16'(len), sent);
            end else if (r < 82) begin
                n_made += add_rx(16'(pick_len()), $urandom_range(6) == 0,
                                 $urandom_range(9) == 0);
            end else if (r < 92) begin
                rx_seq.push_back(mk(CMD_RX_BYTE, 8'($urandom), 16'($urandom)));
                n_made++;
            end else if (r < 96) begin
                tx_seq.push_back(mk(CMD_TX_BYTE, 8'($urandom), 16'($urandom)));
            end else begin
                tx_seq.push_back(mk(CMD_NONE, 8'($urandom), 16'($urandom)));
            end
            if (tx_seq.size() != 0 && rx_seq.size() != 0)
                merge_seqs(1'b1);
        end
        merge_seqs(1'b1);
    endfunction

    task automatic drain_all();
        while (item_q.size() != 0 || i_in_valid || codec_out_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int idle, int stall);
        idle_pct  <= idle;
        stall_pct <= stall;
        gen_random(PHASE_ITEMS);
        drain_all();
    endtask

    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            codec_predict(i_in_item);
            n_in_items++;
        end
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item  <= item_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (codec_out_q.size() == 0) begin
                $error("result with nothing expected: kind %0d out_byte %02h",
                       o_out_item.kind, o_out_item.out_byte);
                n_fail++;
            end else begin
                want_item = codec_out_q.pop_front();
                if (o_out_item.kind !== want_item.kind) begin
                    $error("kind: expected %0d, got %0d", want_item.kind, o_out_item.kind);
                    n_fail++;
                end
                if (o_out_item.out_byte !== want_item.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want_item.out_byte, o_out_item.out_byte);
                    n_fail++;
                end
                if (o_out_item.status !== want_item.status) begin
                    $error("status: expected %0d, got %0d", want_item.status, o_out_item.status);
                    n_fail++;
                end
                if (o_out_item.rx_length !== want_item.rx_length) begin
                    $error("rx_length: expected %0d, got %0d",
                           want_item.rx_length, o_out_item.rx_length);
                    n_fail++;
                end
                if (o_out_item.hold_off !== want_item.hold_off) begin
                    $error("hold_off: expected %0d, got %0d",
                           want_item.hold_off, o_out_item.hold_off);
                    n_fail++;
                end
                if (o_out_item.last !== want_item.last) begin
                    $error("last: expected %0d, got %0d", want_item.last, o_out_item.last);
                    n_fail++;
                end
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_CYCLES) begin
            $error("no item moved on either channel for %0d cycles", hang_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        item_q.push_back(mk(CMD_TX_START, 8'h00, 16'd0));
        item_q.push_back(mk(CMD_TX_START, 8'hff, 16'd2));
        item_q.push_back(mk(CMD_TX_BYTE, 8'hff, 16'hffff));
        item_q.push_back(mk(CMD_TX_START, 8'h00, 16'd1));
        item_q.push_back(mk(CMD_TX_BYTE, 8'h00, 16'h0000));
        item_q.push_back(mk(CMD_TX_BYTE, 8'h5a, 16'h0000));
        item_q.push_back(mk(CMD_NONE, 8'hff, 16'hffff));
        item_q.push_back(mk(CMD_TX_START, 8'h00, 16'd257));
        item_q.push_back(mk(CMD_TX_START, 8'h00, 16'hffff));
        item_q.push_back(mk(CMD_RX_BYTE, 8'hff, 16'hffff));
        item_q.push_back(mk(CMD_TX_START, 8'h00, 16'd0));
        void'(add_rx(16'd0, 1'b0, 1'b0));
        void'(add_rx(16'd1, 1'b1, 1'b0));
        void'(add_rx(16'd257, 1'b0, 1'b0));
        merge_seqs(1'b0);
        item_q.push_back(mk(CMD_TX_START, 8'h00, 16'd0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_all();

        run_phase(0, 0);
        run_phase(58, 0);
        run_phase(0, 58);
        run_phase(23, 23);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d input items (%0d transmit and %0d receive frames, good and broken).",
                 n_in_items, n_tx_frames, n_rx_frames);
        $display("Compared %0d result items under four sender/receiver idling mixes.",
                 n_results);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sohbcc_pkg.sv
rtl/sohbcc_queue.sv
rtl/sohbcc_front.sv
rtl/sohbcc_back.sv
rtl/soh_length_bcc_frame_codec_core.sv
verif/tb.sv
